### sv/mccl_pkg.sv
`timescale 1ns / 1ps

package mccl_pkg;

  // Default sizes of the tables.
  localparam int CHANNELS_DEF    = 16;
  localparam int CELLS_DEF       = 16;
  localparam int CONTROLLERS_DEF = 128;

  // Field widths.
  localparam int ACT_W      = 2;
  localparam int STAT_W     = 4;
  localparam int CH_FIELD_W = 4;
  localparam int CC_W       = 7;
  localparam int VAL_W      = 8;
  localparam int CELL_FLD_W = 4;
  localparam int RAW_W      = 16;
  localparam int LEVEL_W    = 18;
  localparam int GAIN_W     = 16;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = ACT_W;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Action codes carried in tuser.
  localparam logic [ACT_W-1:0] ACT_MIDI   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ARM    = 2'd2;

  // Control change status nibble.
  localparam logic [STAT_W-1:0] STATUS_CC = 4'hB;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MPE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LSB    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd3;

  // Reset value of the smoothing gain.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd41;

  // Number of MSB controllers that pair with an LSB controller.
  localparam int PEND_COUNT = 32;

  // floor(2^31 / 127) for the divide by 127 in the level scaling.
  localparam logic [24:0] RECIP_127   = 25'd16909320;
  localparam int          RECIP_SHIFT = 31;

  // Full scale level in Q1.16.
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 18'd65536;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WRITE2,
    S_CALC,
    S_OUT
  } state_t;

  // Request from the sequencer to the level unit.
  typedef struct packed {
    logic              start;
    logic              smooth;
    logic [GAIN_W-1:0] gain;
  } lvl_req_t;

endpackage

### sv/mccl_level.sv
`timescale 1ns / 1ps

module mccl_level (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mccl_pkg::lvl_req_t                   req,
  input  logic signed [mccl_pkg::RAW_W-1:0]    raw,
  input  logic signed [mccl_pkg::LEVEL_W-1:0]  cur,
  output logic                                 done,
  output logic signed [mccl_pkg::LEVEL_W-1:0]  level
);
  import mccl_pkg::*;

  // Stage valid flags.
  logic v1, v2, v3, v4;

  // Stage 1: magnitude, scaled numerator m = mag * 512 + 63.
  logic [RAW_W-1:0]          mag;
  logic [23:0]               m1;
  logic                      neg1;
  logic signed [LEVEL_W-1:0] cur1;
  logic                      smooth1;
  logic [GAIN_W-1:0]         gain1;

  // Stage 2: reciprocal product.
  logic [48:0]               mul2;
  logic [48:0]               prod2;
  logic [23:0]               m2;
  logic                      neg2;
  logic signed [LEVEL_W-1:0] cur2;
  logic                      smooth2;
  logic [GAIN_W-1:0]         gain2;

  // Stage 3: quotient correction, clamp, sign and difference.
  logic [17:0]               q0;
  logic [24:0]               q0x;
  logic [23:0]               rem;
  logic [17:0]               q;
  logic [17:0]               qc;
  logic signed [LEVEL_W-1:0] target_c;
  logic signed [LEVEL_W:0]   diff_c;
  logic signed [LEVEL_W-1:0] target3;
  logic signed [LEVEL_W:0]   diff3;
  logic signed [LEVEL_W-1:0] cur3;
  logic                      use3;
  logic [GAIN_W-1:0]         gain3;

  // Stage 4: filter product.
  logic signed [35:0]        mul4;
  logic signed [35:0]        p4;
  logic signed [LEVEL_W-1:0] target4;
  logic signed [LEVEL_W-1:0] cur4;
  logic                      use4;

  assign mag = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);

  always_ff @(posedge clk) begin
    if (req.start) begin
      m1      <= {mag[14:0], 9'd63};
      neg1    <= raw[RAW_W-1];
      cur1    <= cur;
      smooth1 <= req.smooth;
      gain1   <= req.gain;
    end
  end

  assign mul2 = m1 * RECIP_127;

  always_ff @(posedge clk) begin
    prod2   <= mul2;
    m2      <= m1;
    neg2    <= neg1;
    cur2    <= cur1;
    smooth2 <= smooth1;
    gain2   <= gain1;
  end

  // The reciprocal estimate is exact or one low; one compare fixes it.
  always_comb begin
    q0  = prod2[RECIP_SHIFT+17:RECIP_SHIFT];
    q0x = {q0, 7'b0} - {7'b0, q0};
    rem = m2 - q0x[23:0];
    q   = (rem >= 24'd127) ? q0 + 18'd1 : q0;
    qc  = (q > LEVEL_ONE) ? LEVEL_ONE : q;
    target_c = neg2 ? $signed(-qc) : $signed(qc);
    diff_c   = (LEVEL_W+1)'(target_c) - (LEVEL_W+1)'(cur2);
  end

  always_ff @(posedge clk) begin
    target3 <= target_c;
    diff3   <= diff_c;
    cur3    <= cur2;
    gain3   <= gain2;
    use3    <= smooth2 && (diff_c > -19'sd65536) && (diff_c < 19'sd65536);
  end

  assign mul4 = diff3 * $signed({1'b0, gain3});

  always_ff @(posedge clk) begin
    p4      <= mul4 + 36'sd32768;
    target4 <= target3;
    cur4    <= cur3;
    use4    <= use3;
  end

  // Stage 5: one-pole step, or jump to the target.
  always_ff @(posedge clk) begin
    if (use4) begin
      level <= cur4 + p4[LEVEL_W+15:16];
    end else begin
      level <= target4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= req.start;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

endmodule

### sv/midi_cc_to_level_mapper_unit.sv
`timescale 1ns / 1ps
// Sequencing: a message or arm beat passes the read, execute and output states before it shows on
// the output; a 14-bit LSB commit that writes two table entries adds a second write state after
// execute, and a sample beat waits in the calc state for the five stage level unit.
// Flow: one item at a time; a new beat is taken only in the idle state, after the output state has
// handed the result to the output register, and it waits there while a held result is not taken.
// Reset: synchronous; after reset a clearing pass zeroes the tables; config writes are taken during it.
module midi_cc_to_level_mapper_unit #(
  parameter int CHANNELS    = mccl_pkg::CHANNELS_DEF,
  parameter int CELLS       = mccl_pkg::CELLS_DEF,
  parameter int CONTROLLERS = mccl_pkg::CONTROLLERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // status_nibble[3:0], midi_channel[7:4], cc_number[14:8], cc_value[22:15],
  // cell_req[26:23], zero fill above
  input  logic [mccl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action[1:0]
  input  logic [mccl_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cell_raw[15:0], level[33:16], learned[34], learned_cell[38:35], zero fill above
  output logic [mccl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mccl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mccl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mccl_pkg::*;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IDX_W   = $clog2(CONTROLLERS + PEND_COUNT);
  localparam int A_AW    = IDX_W + CH_W;
  localparam int A_DEPTH = (CONTROLLERS + PEND_COUNT) * (2 ** CH_W);
  localparam int L_AW    = CELL_W + CH_W;
  localparam int L_DEPTH = CELLS * (2 ** CH_W);

  // Configuration.
  logic              smooth_enable;
  logic              mpe_mode;
  logic              lsb_mode;
  logic [GAIN_W-1:0] filter_gain;

  // Sequencer.
  state_t         state, state_next;
  logic [A_AW-1:0] clr_cnt;
  logic            accept;

  // Item held while it is worked on.
  logic [ACT_W-1:0]      act_q;
  logic [STAT_W-1:0]     stat_q;
  logic [CH_FIELD_W-1:0] ch_q;
  logic [CC_W-1:0]       ctl_q;
  logic [VAL_W-1:0]      val_q;
  logic [CELL_FLD_W-1:0] cell_q;
  logic                  pair_q;

  // Decoded item.
  logic [CH_W-1:0]   ch_idx;
  logic [CELL_W-1:0] cell_idx;
  logic              ch_ok, cell_ok, ctl_ok;
  logic              msg_ok, smp_ok, park, commit;
  logic [CC_W-1:0]   src_raw, src;
  logic              src_pair;
  logic              learn_hit;

  // Learn state and cell map.
  logic                  learn_armed;
  logic [CELL_FLD_W-1:0] learn_cell;
  logic [CC_W-1:0]       cmap [CELLS];

  // Controller value and pending MSB memory.
  logic [VAL_W-1:0] mem_a [A_DEPTH];
  logic             re;
  logic [A_AW-1:0]  ra0, ra1, wa_a;
  logic             we_a;
  logic [VAL_W-1:0] wd_a;
  logic [VAL_W-1:0] rd0, rd1;

  // Smoothed level memory.
  logic signed [LEVEL_W-1:0] mem_l [L_DEPTH];
  logic [L_AW-1:0]           ral, wa_l;
  logic                      we_l;
  logic signed [LEVEL_W-1:0] wd_l;
  logic signed [LEVEL_W-1:0] rdl;

  // Sample arithmetic and level unit.
  logic signed [RAW_W-1:0]   raw_hi, raw_lo, raw_calc;
  lvl_req_t                  lvl_req;
  logic                      lvl_done;
  logic signed [LEVEL_W-1:0] lvl_level;

  // Result of the current item.
  logic [RAW_W-1:0]      res_raw;
  logic [LEVEL_W-1:0]    res_level;
  logic                  res_learned;
  logic [CELL_FLD_W-1:0] res_cell;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_enable <= 1'b1;
      mpe_mode      <= 1'b0;
      lsb_mode      <= 1'b0;
      filter_gain   <= GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SMOOTH: smooth_enable <= cfg_data[0];
        REG_MPE:    mpe_mode      <= cfg_data[0];
        REG_LSB:    lsb_mode      <= cfg_data[0];
        REG_GAIN:   filter_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item on its input beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= s_axis_tuser;
      stat_q <= s_axis_tdata[3:0];
      ch_q   <= mpe_mode ? s_axis_tdata[7:4] : '0;
      ctl_q  <= s_axis_tdata[14:8];
      val_q  <= s_axis_tdata[22:15];
      cell_q <= s_axis_tdata[26:23];
    end
  end

  // Item decode.
  always_comb begin
    ch_ok    = int'(ch_q) < CHANNELS;
    cell_ok  = int'(cell_q) < CELLS;
    ctl_ok   = int'(ctl_q) < CONTROLLERS;
    ch_idx   = ch_ok ? CH_W'(ch_q) : '0;
    cell_idx = cell_ok ? CELL_W'(cell_q) : '0;
    msg_ok   = (act_q == ACT_MIDI) && (stat_q == STATUS_CC) && ch_ok && ctl_ok;
    smp_ok   = (act_q == ACT_SAMPLE) && cell_ok && ch_ok;
    park     = lsb_mode && (ctl_q[6:5] == 2'b00);
    commit   = lsb_mode && (ctl_q[6:5] == 2'b01);
    src_raw  = cmap[cell_idx];
    src      = (int'(src_raw) < CONTROLLERS) ? src_raw : '0;
    src_pair = lsb_mode && (src[6:5] == 2'b00);
    learn_hit = learn_armed && (rd0 != val_q);
  end

  // MSB times 128 plus the paired LSB.
  always_comb begin
    raw_hi   = {rd0[VAL_W-1], rd0, 7'b0};
    raw_lo   = pair_q ? RAW_W'($signed(rd1)) : '0;
    raw_calc = raw_hi + raw_lo;
  end

  // Next state, memory addresses and write strobes.
  always_comb begin
    state_next = state;
    re   = 1'b0;
    ra0  = '0;
    ra1  = '0;
    ral  = '0;
    we_a = 1'b0;
    wa_a = '0;
    wd_a = val_q;
    we_l = 1'b0;
    wa_l = {cell_idx, ch_idx};
    wd_l = lvl_level;
    lvl_req.start  = 1'b0;
    lvl_req.smooth = smooth_enable;
    lvl_req.gain   = filter_gain;
    unique case (state)
      S_CLEAR: begin
        we_a = 1'b1;
        wa_a = clr_cnt;
        wd_a = '0;
        we_l = int'(clr_cnt) < L_DEPTH;
        wa_l = L_AW'(clr_cnt);
        wd_l = '0;
        if (clr_cnt == A_AW'(A_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        re = 1'b1;
        if (smp_ok) begin
          ra0 = {IDX_W'(src), ch_idx};
          ra1 = {IDX_W'({2'b01, src[4:0]}), ch_idx};
          ral = {cell_idx, ch_idx};
        end else if (msg_ok) begin
          ra0 = {IDX_W'(ctl_q), ch_idx};
          ra1 = {IDX_W'(CONTROLLERS) + IDX_W'(ctl_q[4:0]), ch_idx};
        end
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (msg_ok) begin
          we_a = 1'b1;
          if (park) begin
            wa_a = {IDX_W'(CONTROLLERS) + IDX_W'(ctl_q[4:0]), ch_idx};
          end else if (commit) begin
            wa_a = {IDX_W'(ctl_q[4:0]), ch_idx};
            wd_a = rd1;
          end else begin
            wa_a = {IDX_W'(ctl_q), ch_idx};
          end
          state_next = commit ? S_WRITE2 : S_OUT;
        end else if (smp_ok) begin
          lvl_req.start = 1'b1;
          state_next    = S_CALC;
        end else begin
          state_next = S_OUT;
        end
      end
      S_WRITE2: begin
        we_a = 1'b1;
        wa_a = {IDX_W'(ctl_q), ch_idx};
        state_next = S_OUT;
      end
      S_CALC: begin
        if (lvl_done) begin
          we_l = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Controller value and pending MSB memory.
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
    if (re) begin
      rd0 <= mem_a[ra0];
      rd1 <= mem_a[ra1];
    end
  end

  // Smoothed level memory.
  always_ff @(posedge clk) begin
    if (we_l) begin
      mem_l[wa_l] <= wd_l;
    end
    if (re) begin
      rdl <= mem_l[ral];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      pair_q <= src_pair;
    end
  end

  // Learn target and cell map.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_armed <= 1'b0;
      learn_cell  <= '0;
      for (int i = 0; i < CELLS; i++) begin
        cmap[i] <= CC_W'(i);
      end
    end else if (state == S_EXEC) begin
      if (msg_ok && learn_hit) begin
        if (int'(learn_cell) < CELLS) begin
          cmap[CELL_W'(learn_cell)] <= ctl_q;
        end
        learn_armed <= 1'b0;
      end else if ((act_q == ACT_ARM) && cell_ok) begin
        learn_armed <= 1'b1;
        learn_cell  <= cell_q;
      end
    end
  end

  // Result fields of the current item.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_raw     <= '0;
      res_level   <= '0;
      res_learned <= 1'b0;
      res_cell    <= '0;
    end else if (state == S_EXEC) begin
      if (msg_ok && learn_hit) begin
        res_learned <= 1'b1;
        res_cell    <= learn_cell;
      end
      if (smp_ok) begin
        res_raw <= raw_calc;
      end
    end else if ((state == S_CALC) && lvl_done) begin
      res_level <= lvl_level;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {1'b0, res_cell, res_learned, res_level, res_raw};
    end
  end

  mccl_level u_level (
    .clk   (clk),
    .rst   (rst),
    .req   (lvl_req),
    .raw   (raw_calc),
    .cur   (rdl),
    .done  (lvl_done),
    .level (lvl_level)
  );

  // The level unit only finishes while the sequencer waits for it.
  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    lvl_done |-> (state == S_CALC))
    else $error("level unit finished outside of the calc state");

  // The second table write always follows the first one of an LSB commit.
  a_write2_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE2) |-> ($past(state) == S_EXEC))
    else $error("second write without a preceding commit write");

  // Levels stay within minus one to one.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (($signed(m_axis_tdata[33:16]) <= 18'sd65536) &&
                       ($signed(m_axis_tdata[33:16]) >= -18'sd65536)))
    else $error("level out of range");

  // A learned cell is only reported together with the learned flag.
  a_learn_cell: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[34]) |-> (m_axis_tdata[38:35] == '0))
    else $error("learned cell without learned flag");

endmodule
